### hw/rtl/btn_dbc_pkg.sv
// Shared types and constants for the button debounce and click detector.
// No dependencies; imported by button_debounce_click_detector_unit.
`default_nettype none

package btn_dbc_pkg;

    // Item modes
    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_PRIME  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Register indexes on the APB port (byte address = 4 * index)
    localparam logic [2:0] REG_ACTIVE_LOW  = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS  = 3'd2;
    localparam logic [2:0] REG_MULTI_CLICK = 3'd3;
    localparam logic [2:0] REG_BOOT_HOLD   = 3'd4;

    localparam int unsigned ADDR_W = 5;

    // Register reset values
    localparam logic        RST_ACTIVE_LOW  = 1'b1;
    localparam logic [15:0] RST_DEBOUNCE    = 16'd50;
    localparam logic [31:0] RST_LONG_PRESS  = 32'd1000;
    localparam logic [15:0] RST_MULTI_CLICK = 16'd300;
    localparam logic [31:0] RST_BOOT_HOLD   = 32'd3000;

    localparam logic [7:0] TALLY_MAX = 8'hFF;

    // Event codes
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_LONG    = 3'd3,
        EV_DOUBLE  = 3'd4,
        EV_MULTI   = 3'd5,
        EV_BOOT    = 3'd6
    } t_event;

    // Button tracking state
    typedef struct packed {
        logic        raw_seen;
        logic        stable_level;
        logic        is_held;
        logic        long_fired;
        logic [31:0] change_stamp;
        logic [31:0] press_stamp;
        logic [31:0] release_stamp;
        logic [31:0] start_stamp;
        logic [31:0] held_length;
        logic [7:0]  click_tally;
        logic [7:0]  last_tally;
        logic        boot_armed;
        logic        boot_fired;
    } t_state;

    localparam t_state STATE_ZERO = '0;

endpackage

`default_nettype wire

### hw/rtl/button_debounce_click_detector_unit.sv
// Button debounce, long press, multi-click and boot-hold detector, top level.
// An accepted input word is held in the input register; its result word is written to
// the result register once the result slot is empty or being drained. Throughput: one
// word per cycle while the result side does not stall, set by the combinational state
// update between the two registers. Synchronous active-low reset clears the button
// state and the handshake; config registers return to defaults.
// Depends on btn_dbc_pkg.
`default_nettype none

module button_debounce_click_detector_unit
    import btn_dbc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input channel
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_mode,
    input  wire logic                i_pin_level,
    input  wire logic [31:0]         i_now_ms,
    // Result channel
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [2:0]               o_event_res,
    output logic                     o_pressed,
    output logic [7:0]               o_done_clicks,
    output logic [7:0]               o_last_click_total,
    output logic [31:0]              o_held_duration,
    output logic [31:0]              o_last_held_duration,
    // APB config port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // Config registers
    logic        r_active_low;
    logic [15:0] r_debounce;
    logic [31:0] r_long_press;
    logic [15:0] r_multi_click;
    logic [31:0] r_boot_hold;

    logic [2:0] w_reg_idx;
    logic       w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low  <= RST_ACTIVE_LOW;
            r_debounce    <= RST_DEBOUNCE;
            r_long_press  <= RST_LONG_PRESS;
            r_multi_click <= RST_MULTI_CLICK;
            r_boot_hold   <= RST_BOOT_HOLD;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_ACTIVE_LOW:  r_active_low  <= pwdata[0];
                REG_DEBOUNCE:    r_debounce    <= pwdata[15:0];
                REG_LONG_PRESS:  r_long_press  <= pwdata;
                REG_MULTI_CLICK: r_multi_click <= pwdata[15:0];
                REG_BOOT_HOLD:   r_boot_hold   <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (w_reg_idx)
            REG_ACTIVE_LOW:  prdata = {31'd0, r_active_low};
            REG_DEBOUNCE:    prdata = {16'd0, r_debounce};
            REG_LONG_PRESS:  prdata = r_long_press;
            REG_MULTI_CLICK: prdata = {16'd0, r_multi_click};
            REG_BOOT_HOLD:   prdata = r_boot_hold;
            default:         prdata = 32'd0;
        endcase
    end

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_in_mode;
    logic        r_in_pin;
    logic [31:0] r_in_now;

    // Result register
    logic        r_out_valid;
    t_event      r_out_event;
    logic        r_out_pressed;
    logic [7:0]  r_out_final;
    logic [7:0]  r_out_last_tally;
    logic [31:0] r_out_held_dur;
    logic [31:0] r_out_last_held;

    t_state r_st;
    t_state n_st;
    t_event n_event;
    logic [7:0]  n_final;
    logic [31:0] n_held_dur;

    logic w_adv;

    // Advance when the result slot is empty or being drained
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_mode <= i_mode;
            r_in_pin  <= i_pin_level;
            r_in_now  <= i_now_ms;
        end
    end

    // Step logic
    logic        w_raw_p;
    logic        w_chg;
    logic [31:0] w_since_chg;
    logic        w_edge;
    logic        w_press_edge;
    logic        w_rel_edge;
    logic [31:0] w_since_press;
    logic [31:0] w_since_prev_rel;
    logic [31:0] w_since_rel;
    logic [31:0] w_since_start;
    logic [31:0] w_held_dur_raw;
    logic [31:0] w_window;

    assign w_raw_p          = r_active_low ? !r_in_pin : r_in_pin;
    assign w_window         = {16'd0, r_multi_click};
    assign w_chg            = w_raw_p != r_st.raw_seen;
    // A fresh change restarts the debounce count at zero
    assign w_since_chg      = w_chg ? 32'd0 : (r_in_now - r_st.change_stamp);
    assign w_edge           = (w_since_chg >= {16'd0, r_debounce})
                              && (w_raw_p != r_st.stable_level);
    assign w_press_edge     = w_edge && w_raw_p;
    assign w_rel_edge       = w_edge && !w_raw_p;
    assign w_since_press    = w_press_edge ? 32'd0 : (r_in_now - r_st.press_stamp);
    assign w_since_prev_rel = r_in_now - r_st.release_stamp;
    assign w_since_rel      = w_rel_edge ? 32'd0 : w_since_prev_rel;
    assign w_since_start    = r_in_now - r_st.start_stamp;
    assign w_held_dur_raw   = r_in_now - n_st.press_stamp;

    always_comb begin
        n_st       = r_st;
        n_event    = EV_NONE;
        n_final    = 8'd0;
        case (r_in_mode)
            MODE_PRIME: begin
                n_st              = STATE_ZERO;
                n_st.start_stamp  = r_in_now;
                n_st.raw_seen     = w_raw_p;
                n_st.stable_level = w_raw_p;
                n_st.is_held      = w_raw_p;
                n_st.press_stamp  = r_in_now;
                n_st.change_stamp = r_in_now;
                n_st.boot_armed   = w_raw_p;
            end
            MODE_CLEAR: begin
                n_st             = STATE_ZERO;
                n_st.start_stamp = r_in_now;
            end
            MODE_UPDATE: begin
                // Raw level tracking
                n_st.raw_seen = w_raw_p;
                if (w_chg) begin
                    n_st.change_stamp = r_in_now;
                end
                // Debounced edges
                if (w_press_edge) begin
                    n_st.stable_level = 1'b1;
                    n_st.is_held      = 1'b1;
                    n_st.long_fired   = 1'b0;
                    n_st.press_stamp  = r_in_now;
                    n_event           = EV_PRESS;
                end else if (w_rel_edge) begin
                    n_st.stable_level  = 1'b0;
                    n_st.is_held       = 1'b0;
                    n_st.release_stamp = r_in_now;
                    n_st.held_length   = r_in_now - r_st.press_stamp;
                    if (r_st.long_fired) begin
                        n_st.click_tally = 8'd0;
                    end else if (r_st.click_tally == 8'd0 || w_since_prev_rel < w_window) begin
                        if (r_st.click_tally != TALLY_MAX) begin
                            n_st.click_tally = r_st.click_tally + 8'd1;
                        end
                    end else begin
                        n_st.click_tally = 8'd1;
                    end
                    n_st.boot_armed = 1'b0;
                    n_event         = EV_RELEASE;
                end
                // Long press, once per press
                if (n_st.is_held && !n_st.long_fired && w_since_press >= r_long_press) begin
                    n_st.long_fired  = 1'b1;
                    n_st.click_tally = 8'd0;
                    n_event          = EV_LONG;
                end
                // Boot hold, once after priming
                if (n_st.boot_armed && !r_st.boot_fired && n_st.is_held
                    && w_since_start >= r_boot_hold) begin
                    n_st.boot_fired = 1'b1;
                    n_event         = EV_BOOT;
                end
                // Finalize the click sequence once the window expires
                if (n_st.click_tally != 8'd0 && !n_st.is_held && w_since_rel >= w_window) begin
                    n_final          = n_st.click_tally;
                    n_st.last_tally  = n_st.click_tally;
                    n_st.click_tally = 8'd0;
                    if (n_final == 8'd2) begin
                        n_event = EV_DOUBLE;
                    end else if (n_final > 8'd2) begin
                        n_event = EV_MULTI;
                    end
                end
            end
            default: ;
        endcase
        n_held_dur = n_st.is_held ? w_held_dur_raw : 32'd0;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_ZERO;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_event      <= n_event;
            r_out_pressed    <= n_st.is_held;
            r_out_final      <= n_final;
            r_out_last_tally <= n_st.last_tally;
            r_out_held_dur   <= n_held_dur;
            r_out_last_held  <= n_st.held_length;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_event_res          = r_out_event;
    assign o_pressed            = r_out_pressed;
    assign o_done_clicks        = r_out_final;
    assign o_last_click_total   = r_out_last_tally;
    assign o_held_duration      = r_out_held_dur;
    assign o_last_held_duration = r_out_last_held;

    // Assertions
    a_held_matches_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.is_held == r_st.stable_level)
        else $error("held flag and debounced level disagree");

    a_long_clears_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.is_held && r_st.long_fired) |-> (r_st.click_tally == 8'd0))
        else $error("click tally nonzero during a long press");

    a_press_event_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_PRESS) |-> r_out_pressed)
        else $error("press event without pressed state");

    a_final_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_final != 8'd0) |-> (r_out_last_tally == r_out_final))
        else $error("finalized count not recorded as last total");

    a_input_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("buffered word did not reach the result register");

endmodule

`default_nettype wire

### sim/button_debounce_click_detector_unit_test.sv
// Self-checking bench for button_debounce_click_detector_unit: directed table, gestures, then
// a click burst. Needs btn_dbc_pkg and unit RTL; expected words: typed table or predictor.
module button_debounce_click_detector_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import btn_dbc_pkg::*;

    // Mode 3 is left undecoded by the unit
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    typedef struct packed {
        t_event      ev;
        logic        pressed;
        logic [7:0]  done_clicks;
        logic [7:0]  last_total;
        logic [31:0] held;
        logic [31:0] last_held;
    } t_click_result;

    typedef struct packed {
        logic [1:0]    mode;
        logic          pin;
        logic [31:0]   now_ms;
        logic          typed;
        t_click_result want;
    } t_stim_row;

    localparam t_click_result RESULT_IDLE   = '{EV_NONE, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0};
    localparam t_click_result RESULT_PRIMED = '{EV_NONE, 1'b1, 8'd0, 8'd0, 32'd0, 32'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = MODE_UPDATE;
    logic        i_pin_level = 1'b1;
    logic [31:0] i_now_ms = 32'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_event_res;
    logic        o_pressed;
    logic [7:0]  o_done_clicks;
    logic [7:0]  o_last_click_total;
    logic [31:0] o_held_duration;
    logic [31:0] o_last_held_duration;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    button_debounce_click_detector_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_mode               (i_mode),
        .i_pin_level          (i_pin_level),
        .i_now_ms             (i_now_ms),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_event_res          (o_event_res),
        .o_pressed            (o_pressed),
        .o_done_clicks        (o_done_clicks),
        .o_last_click_total   (o_last_click_total),
        .o_held_duration      (o_held_duration),
        .o_last_held_duration (o_last_held_duration),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always #1ns i_clk = ~i_clk;

    // Predictor copy of the button state and registers
    t_state      btn_st = STATE_ZERO;
    logic        cfg_active_low = RST_ACTIVE_LOW;
    logic [15:0] cfg_debounce = RST_DEBOUNCE;
    logic [31:0] cfg_long_press = RST_LONG_PRESS;
    logic [15:0] cfg_multi_click = RST_MULTI_CLICK;
    logic [31:0] cfg_boot_hold = RST_BOOT_HOLD;

    t_click_result expected_q[$];
    t_stim_row     dir_rows[$];
    int unsigned   mismatches = 0;
    int unsigned   results_seen = 0;
    int unsigned   words_sent = 0;
    int unsigned   ev_count[0:7];
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    logic [31:0]   clock_ms = 32'd0;

    // One step of the button: debounce, edges, long press, boot hold, click finalize
    function automatic t_click_result predict_button_step(input logic [1:0] m, input logic p,
                                                          input logic [31:0] t);
        t_click_result r;
        logic          down;
        logic [31:0]   since;
        logic [31:0]   prev_rel;
        logic [7:0]    fin;
        t_event        ev;
        down = cfg_active_low ? (p == 1'b0) : (p == 1'b1);
        ev = EV_NONE;
        fin = 8'd0;
        case (m)
            MODE_PRIME: begin
                btn_st = STATE_ZERO;
                btn_st.start_stamp = t;
                btn_st.raw_seen = down;
                btn_st.stable_level = down;
                btn_st.is_held = down;
                btn_st.press_stamp = t;
                btn_st.change_stamp = t;
                btn_st.boot_armed = down;
            end
            MODE_CLEAR: begin
                btn_st = STATE_ZERO;
                btn_st.start_stamp = t;
            end
            MODE_UPDATE: begin
                if (down != btn_st.raw_seen) begin
                    btn_st.raw_seen = down;
                    btn_st.change_stamp = t;
                end
                since = t - btn_st.change_stamp;
                if (since >= {16'd0, cfg_debounce} && down != btn_st.stable_level) begin
                    btn_st.stable_level = down;
                    if (down) begin
                        btn_st.is_held = 1'b1;
                        btn_st.long_fired = 1'b0;
                        btn_st.press_stamp = t;
                        ev = EV_PRESS;
                    end else begin
                        prev_rel = btn_st.release_stamp;
                        btn_st.is_held = 1'b0;
                        btn_st.release_stamp = t;
                        btn_st.held_length = t - btn_st.press_stamp;
                        since = t - prev_rel;
                        if (btn_st.long_fired) begin
                            btn_st.click_tally = 8'd0;
                        end else if (btn_st.click_tally == 8'd0 ||
                                     since < {16'd0, cfg_multi_click}) begin
                            // tally sticks at its ceiling
                            if (btn_st.click_tally < TALLY_MAX)
                                btn_st.click_tally = btn_st.click_tally + 8'd1;
                        end else begin
                            btn_st.click_tally = 8'd1;
                        end
                        btn_st.boot_armed = 1'b0;
                        ev = EV_RELEASE;
                    end
                end
                since = t - btn_st.press_stamp;
                if (btn_st.is_held && !btn_st.long_fired && since >= cfg_long_press) begin
                    btn_st.long_fired = 1'b1;
                    btn_st.click_tally = 8'd0;
                    ev = EV_LONG;
                end
                since = t - btn_st.start_stamp;
                if (btn_st.boot_armed && !btn_st.boot_fired && btn_st.is_held &&
                    since >= cfg_boot_hold) begin
                    btn_st.boot_fired = 1'b1;
                    ev = EV_BOOT;
                end
                since = t - btn_st.release_stamp;
                if (btn_st.click_tally != 8'd0 && !btn_st.is_held &&
                    since >= {16'd0, cfg_multi_click}) begin
                    fin = btn_st.click_tally;
                    btn_st.last_tally = btn_st.click_tally;
                    btn_st.click_tally = 8'd0;
                    if (fin == 8'd2)
                        ev = EV_DOUBLE;
                    else if (fin > 8'd2)
                        ev = EV_MULTI;
                end
            end
            default: ;
        endcase
        r.ev = ev;
        r.pressed = btn_st.is_held;
        r.done_clicks = fin;
        r.last_total = btn_st.last_tally;
        r.held = btn_st.is_held ? t - btn_st.press_stamp : 32'd0;
        r.last_held = btn_st.held_length;
        return r;
    endfunction

    function automatic logic pin_for(input logic down);
        return cfg_active_low ? ~down : down;
    endfunction

    // Offer one word; the expectation is queued at the accepting edge
    task automatic send_word(input logic [1:0] m, input logic p, input logic [31:0] t,
                             input logic typed, input t_click_result want);
        t_click_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_pin_level <= p;
        i_now_ms <= t;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_button_step(m, p, t);
        expected_q.push_back(typed ? want : predicted);
        if (m != MODE_IGNORED)
            words_sent++;
    endtask

    task automatic send_update(input logic p, input logic [31:0] dt);
        clock_ms = clock_ms + dt;
        send_word(MODE_UPDATE, p, clock_ms, 1'b0, RESULT_IDLE);
    endtask

    function automatic logic [31:0] pick_gap();
        case ($urandom_range(4))
            0: return $urandom_range(20);
            1: return $urandom_range(cfg_debounce + 20);
            2: return $urandom_range(cfg_multi_click + 20);
            3: return $urandom_range(5000);
            default: return $urandom;
        endcase
    endfunction

    // Contact bounce, then a level held long enough to pass the debounce
    task automatic make_edge(input logic down);
        int unsigned bounces;
        bounces = $urandom_range(2);
        for (int k = 0; k < bounces; k++) begin
            send_update(pin_for(down), $urandom_range(cfg_debounce / 4));
            send_update(pin_for(~down), $urandom_range(cfg_debounce / 4));
        end
        send_update(pin_for(down), $urandom_range(cfg_debounce / 4));
        send_update(pin_for(down), cfg_debounce + $urandom_range(2));
    endtask

    task automatic run_gesture();
        int unsigned kind;
        int unsigned n;
        logic [1:0]  m;
        logic [31:0] hold_ms;
        kind = $urandom_range(99);
        if (kind < 45) begin
            // click train, then idle past the window
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                make_edge(1'b1);
                send_update(pin_for(1'b1), $urandom_range(cfg_multi_click / 2));
                make_edge(1'b0);
                if (k + 1 < n)
                    send_update(pin_for(1'b0), $urandom_range(cfg_multi_click));
            end
            send_update(pin_for(1'b0), cfg_multi_click + $urandom_range(3));
        end else if (kind < 60) begin
            // long press
            make_edge(1'b1);
            hold_ms = (cfg_long_press > 20) ? cfg_long_press - $urandom_range(20) : 32'd0;
            send_update(pin_for(1'b1), hold_ms);
            send_update(pin_for(1'b1), $urandom_range(40));
            make_edge(1'b0);
        end else if (kind < 72) begin
            // usually held at start, then held until around the end of the boot window
            clock_ms = clock_ms + pick_gap();
            send_word(MODE_PRIME, pin_for($urandom_range(3) != 0), clock_ms, 1'b0, RESULT_IDLE);
            hold_ms = (cfg_boot_hold > 30) ? cfg_boot_hold - $urandom_range(30) : 32'd0;
            send_update(pin_for(1'b1), hold_ms);
            send_update(pin_for(1'b1), $urandom_range(60));
            make_edge(1'b0);
        end else if (kind < 80) begin
            clock_ms = clock_ms + pick_gap();
            send_word(MODE_CLEAR, 1'($urandom_range(1)), clock_ms, 1'b0, RESULT_IDLE);
        end else begin
            // noise: any mode, any level, jumps in time
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                m = 2'($urandom_range(3));
                if ($urandom_range(4) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + pick_gap();
                send_word(m, 1'($urandom_range(1)), clock_ms, 1'b0, RESULT_IDLE);
            end
        end
    endtask

    // Lower valid and let every queued word come back
    task automatic wait_drained();
        int unsigned spin;
        spin = 0;
        i_valid <= 1'b0;
        while (expected_q.size() != 0 && spin < 20000) begin
            @(posedge i_clk);
            spin++;
        end
        if (expected_q.size() != 0) begin
            $error("%0d expected words never arrived", expected_q.size());
            mismatches++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic set_config(input logic al, input logic [15:0] db, input logic [31:0] lp,
                              input logic [15:0] mcw, input logic [31:0] bh);
        write_reg(REG_ACTIVE_LOW, {31'd0, al});
        write_reg(REG_DEBOUNCE, {16'd0, db});
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_MULTI_CLICK, {16'd0, mcw});
        write_reg(REG_BOOT_HOLD, bh);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_active_low = al;
        cfg_debounce = db;
        cfg_long_press = lp;
        cfg_multi_click = mcw;
        cfg_boot_hold = bh;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 40)
                $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: compare each accepted word, then stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_event_res <= 3'd7)
                ev_count[o_event_res]++;
            if (expected_q.size() == 0) begin
                if (mismatches < 40)
                    $error("result word with nothing expected");
                mismatches++;
            end else begin
                check_field("event_res", 32'(expected_q[0].ev), 32'(o_event_res));
                check_field("pressed", 32'(expected_q[0].pressed), 32'(o_pressed));
                check_field("done_clicks", 32'(expected_q[0].done_clicks),
                            32'(o_done_clicks));
                check_field("last_click_total", 32'(expected_q[0].last_total),
                            32'(o_last_click_total));
                check_field("held_duration", expected_q[0].held, o_held_duration);
                check_field("last_held_duration", expected_q[0].last_held,
                            o_last_held_duration);
                void'(expected_q.pop_front());
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #800us;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned goal;
        foreach (ev_count[k])
            ev_count[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at reset settings (pin low = pressed)
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_0000, 1'b1, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_IGNORED, 1'b0, 32'hFFFF_FFFF, 1'b1, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_PRIME,   1'b0, 32'h0000_0064, 1'b1, RESULT_PRIMED});
        // long press and boot hold in one step
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_0C1C, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_0C26, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_0C58, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_CLEAR,   1'b1, 32'hFFFF_FF00, 1'b1, RESULT_IDLE});
        // single click across the timestamp wrap, finalized without an event
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'hFFFF_FFF8, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_002A, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_0050, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_0082, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_01AE, 1'b0, RESULT_IDLE});
        // double click
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_0200, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_0232, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_0240, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_0272, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_0280, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_02B2, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_02C0, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_02F2, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_041E, 1'b0, RESULT_IDLE});
        // plain long press, release left pending
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_0500, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_0532, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b0, 32'h0000_091A, 1'b0, RESULT_IDLE});
        dir_rows.push_back(t_stim_row'{MODE_UPDATE,  1'b1, 32'h0000_0920, 1'b0, RESULT_IDLE});

        send_idle_pct = 6;
        recv_stall_pct = 6;
        foreach (dir_rows[k])
            send_word(dir_rows[k].mode, dir_rows[k].pin, dir_rows[k].now_ms,
                      dir_rows[k].typed, dir_rows[k].want);
        clock_ms = dir_rows[dir_rows.size() - 1].now_ms;
        wait_drained();

        // Gesture phases, each with its own settings and idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    set_config(RST_ACTIVE_LOW, RST_DEBOUNCE, RST_LONG_PRESS,
                               RST_MULTI_CLICK, RST_BOOT_HOLD);
                end
                1: begin
                    send_idle_pct = 53;
                    recv_stall_pct = 0;
                    set_config(1'b0, 16'd0, 32'd0, 16'd0, 32'd0);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 53;
                    set_config(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
                end
                default: begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                    set_config(1'b0, 16'd12, 32'd400, 16'd150, 32'd900);
                end
            endcase
            goal = words_sent + 40;
            while (words_sent < goal)
                run_gesture();
            wait_drained();
        end

        // Click burst long enough to pin the tally at its ceiling
        send_idle_pct = 6;
        recv_stall_pct = 6;
        set_config(1'b1, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd2000);
        clock_ms = $urandom;
        send_word(MODE_CLEAR, 1'b1, clock_ms, 1'b0, RESULT_IDLE);
        for (int k = 0; k < 260; k++) begin
            send_update(pin_for(1'b1), $urandom_range(1, 200));
            send_update(pin_for(1'b0), $urandom_range(1, 200));
        end
        send_update(pin_for(1'b0), 32'd65535 + $urandom_range(10));
        wait_drained();

        $display("ran %0d words, %0d results checked across five register settings",
                 words_sent, results_seen);
        $display("events: press %0d release %0d long %0d double %0d multi %0d boot %0d",
                 ev_count[EV_PRESS], ev_count[EV_RELEASE], ev_count[EV_LONG],
                 ev_count[EV_DOUBLE], ev_count[EV_MULTI], ev_count[EV_BOOT]);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
